FILE: src/agc_pkg.sv
// ----------------------------------------------------------------------------
// agc_pkg: shared types and constants of the asteroid gravity unit
// Beat layouts, planet entry layout, register map and fixed limits.
// ----------------------------------------------------------------------------
package agc_pkg;

    // register map, word index into the configuration space
    localparam logic [1:0] REG_COUNT  = 2'd0;
    localparam logic [1:0] REG_SUN    = 2'd1;
    localparam logic [1:0] REG_GAIN   = 2'd2;
    localparam logic [1:0] REG_MARGIN = 2'd3;

    localparam logic [4:0]  COUNT_RST  = 5'd0;
    localparam logic [31:0] SUN_RST    = 32'd65536;
    localparam logic [31:0] GAIN_RST   = 32'd4294967;
    localparam logic [31:0] MARGIN_RST = 32'd1;

    // request kinds
    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    // datapath widths and caps
    localparam int DIV_W = 64;
    localparam int D2_W  = 54;
    localparam logic [63:0] QUOT_CAP = (64'd1 << 47) - 64'd1;
    localparam logic [63:0] TERM_CAP = (64'd1 << 48) - 64'd1;

    typedef struct packed {
        logic              kind;
        logic [3:0]        slot;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic [31:0]       body_radius;
        logic [31:0]       body_mass;
    } t_in_beat;

    typedef struct packed {
        logic              collided;
        logic signed [31:0] force_x;
        logic signed [31:0] force_y;
        logic signed [31:0] force_z;
    } t_out_beat;

    typedef struct packed {
        logic [31:0] px;
        logic [31:0] py;
        logic [31:0] pz;
        logic [31:0] rad;
        logic [31:0] mass;
    } t_planet;

endpackage

FILE: src/agc_if.sv
// ----------------------------------------------------------------------------
// agc_if: valid/ready channels of the asteroid gravity unit
// Request channel carries writes and queries, response channel the results.
// ----------------------------------------------------------------------------
interface agc_req_if;
    logic               valid;
    logic               ready;
    agc_pkg::t_in_beat  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface agc_rsp_if;
    logic               valid;
    logic               ready;
    agc_pkg::t_out_beat data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: src/agc_cell.sv
// ----------------------------------------------------------------------------
// agc_cell: one planet slot of the rotating planet ring
// Holds one entry, loads it on a write and takes the neighbor's on a shift.
// ----------------------------------------------------------------------------
module agc_cell (
    input  logic             i_clk,
    input  logic             i_load,
    input  agc_pkg::t_planet i_load_data,
    input  logic             i_shift,
    input  agc_pkg::t_planet i_next,
    output agc_pkg::t_planet o_entry
);
    import agc_pkg::*;

    t_planet r_entry;

    // load a written entry, or advance the ring by one place
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_entry <= i_load_data;
        end else if (i_shift) begin
            r_entry <= i_next;
        end
    end

    assign o_entry = r_entry;

endmodule

FILE: src/agc_div.sv
// ----------------------------------------------------------------------------
// agc_div: shared restoring divider
// Unsigned 64 by 64 bit division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module agc_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [agc_pkg::DIV_W-1:0] i_num,
    input  logic [agc_pkg::DIV_W-1:0] i_den,
    output logic                      o_done,
    output logic [agc_pkg::DIV_W-1:0] o_quot
);
    import agc_pkg::*;

    localparam int CW = $clog2(DIV_W + 1);

    logic [CW-1:0]    r_cnt;
    logic             r_done;
    logic [DIV_W:0]   r_rem;
    logic [DIV_W-1:0] r_num;
    logic [DIV_W-1:0] r_den;
    logic [DIV_W:0]   w_rem_s;
    logic             w_ge;

    // shift in the next dividend bit and try the subtract
    assign w_rem_s = {r_rem[DIV_W-1:0], r_num[DIV_W-1]};
    assign w_ge    = w_rem_s >= {1'b0, r_den};

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_cnt  <= CW'(DIV_W);
            r_done <= 1'b0;
        end else begin
            r_done <= (r_cnt == CW'(1));
            if (r_cnt != '0) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    // datapath, quotient bits replace dividend bits
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_num <= i_num;
            r_den <= i_den;
        end else if (r_cnt != '0) begin
            r_rem <= w_ge ? (w_rem_s - {1'b0, r_den}) : w_rem_s;
            r_num <= {r_num[DIV_W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_num;

endmodule

FILE: src/asteroid_gravity_and_collision.sv
// A query answer turns valid after a collision pass over the ring and, unless a body is
// hit, a force pass in which each planet that adds force takes a 34-step square root and
// two divisions per axis; a collision answers without the force pass. One item is in
// work at a time; the next beat is taken the cycle after the answer beat. Reset
// (synchronous, active low) clears control and the registers to their defaults; the
// planet table holds no reset value.
// ----------------------------------------------------------------------------
// asteroid_gravity_and_collision: planet table, collision test and force sum
// Planets sit in a ring of cells that rotates past one shared arithmetic unit.
// ----------------------------------------------------------------------------
module asteroid_gravity_and_collision #(
    parameter int MAX_PLANETS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    agc_req_if.sink     i_req,
    agc_rsp_if.source   o_rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import agc_pkg::*;

    localparam int KW = $clog2(MAX_PLANETS + 1);
    localparam int SW = 50 + $clog2(MAX_PLANETS + 1);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_CSQ  = 4'd1;
    localparam logic [3:0] S_CCMP = 4'd2;
    localparam logic [3:0] S_CPL  = 4'd3;
    localparam logic [3:0] S_CSH  = 4'd4;
    localparam logic [3:0] S_FPL  = 4'd5;
    localparam logic [3:0] S_FSQ  = 4'd6;
    localparam logic [3:0] S_FCHK = 4'd7;
    localparam logic [3:0] S_SQRT = 4'd8;
    localparam logic [3:0] S_MUL  = 4'd9;
    localparam logic [3:0] S_DV1  = 4'd10;
    localparam logic [3:0] S_DV2  = 4'd11;
    localparam logic [3:0] S_FSH  = 4'd12;
    localparam logic [3:0] S_SC1  = 4'd13;
    localparam logic [3:0] S_SC2  = 4'd14;
    localparam logic [3:0] S_OUT  = 4'd15;

    // configuration registers
    logic [4:0]  r_count;
    logic [31:0] r_sun;
    logic [31:0] r_gain;
    logic [31:0] r_margin;

    // control
    logic [3:0]    r_state;
    logic [1:0]    r_ax;
    logic [KW-1:0] r_k;
    logic [KW-1:0] r_n;
    logic          r_at_sun;
    logic          r_hit;
    logic [5:0]    r_it;

    // datapath
    logic signed [31:0] r_px;
    logic signed [31:0] r_py;
    logic signed [31:0] r_pz;
    logic [31:0]        r_arad;
    logic [D2_W-1:0]    r_d2;
    logic [D2_W-1:0]    r_lim;
    logic [67:0]        r_sx;
    logic [37:0]        r_rem;
    logic [33:0]        r_root;
    logic signed [SW-1:0] r_sum [0:2];
    logic [31:0]        r_p;
    logic [31:0]        r_force [0:2];

    t_planet w_entry [0:MAX_PLANETS-1];
    t_planet w_head;
    logic    w_wr;
    logic    w_acc;
    logic    w_shift;
    logic    w_cfg_wr;

    // ring of planet cells, cell 0 faces the arithmetic unit
    assign w_acc   = i_req.valid && i_req.ready;
    assign w_wr    = w_acc && (i_req.data.kind == KIND_WRITE);
    assign w_shift = (r_state == S_CSH) || (r_state == S_FSH);

    generate
        for (genvar g = 0; g < MAX_PLANETS; g++) begin : g_cell
            t_planet w_ld;
            assign w_ld.px   = i_req.data.pos_x;
            assign w_ld.py   = i_req.data.pos_y;
            assign w_ld.pz   = i_req.data.pos_z;
            assign w_ld.rad  = i_req.data.body_radius;
            assign w_ld.mass = i_req.data.body_mass;
            agc_cell u_cell (
                .i_clk       (i_clk),
                .i_load      (w_wr && (32'(i_req.data.slot) == g)),
                .i_load_data (w_ld),
                .i_shift     (w_shift),
                .i_next      (w_entry[(g + 1) % MAX_PLANETS]),
                .o_entry     (w_entry[g])
            );
        end
    endgenerate

    assign w_head = w_entry[0];

    // differences to the current body, the sun sits at the origin
    logic [31:0]        w_hx, w_hy, w_hz;
    logic signed [32:0] w_dx, w_dy, w_dz, w_dsel;
    logic [32:0]        w_dmag;
    logic [33:0]        w_lim_op, w_sq_op;
    logic [67:0]        w_sq_full;
    logic [D2_W-1:0]    w_sq;

    assign w_hx = r_at_sun ? 32'd0 : w_head.px;
    assign w_hy = r_at_sun ? 32'd0 : w_head.py;
    assign w_hz = r_at_sun ? 32'd0 : w_head.pz;
    assign w_dx = $signed({w_hx[31], w_hx}) - $signed({r_px[31], r_px});
    assign w_dy = $signed({w_hy[31], w_hy}) - $signed({r_py[31], r_py});
    assign w_dz = $signed({w_hz[31], w_hz}) - $signed({r_pz[31], r_pz});

    always_comb begin
        case (r_ax)
            2'd0:    w_dsel = w_dx;
            2'd1:    w_dsel = w_dy;
            default: w_dsel = w_dz;
        endcase
    end

    assign w_dmag   = w_dsel[32] ? 33'(-w_dsel) : 33'(w_dsel);
    assign w_lim_op = r_at_sun ? {2'b00, r_sun}
                               : {1'b0, 33'(w_head.rad) + 33'(r_arad)};
    assign w_sq_op  = (r_state == S_CSQ && r_ax == 2'd3) ? w_lim_op : {1'b0, w_dmag};
    assign w_sq_full = w_sq_op * w_sq_op;
    assign w_sq     = D2_W'(w_sq_full[67:16]);

    // square root step
    logic [37:0] w_rem_s;
    logic [37:0] w_trial;
    assign w_rem_s = {r_rem[35:0], r_sx[67:66]};
    assign w_trial = {2'b00, r_root, 2'b01};

    // shared divider
    logic             w_div_start;
    logic [DIV_W-1:0] w_div_num;
    logic [DIV_W-1:0] w_div_den;
    logic             w_div_done;
    logic [DIV_W-1:0] w_quot;
    logic [63:0]      w_q;
    logic [63:0]      w_t;

    assign w_q = (w_quot > QUOT_CAP) ? QUOT_CAP : w_quot;
    assign w_t = (w_quot > TERM_CAP) ? TERM_CAP : w_quot;

    always_comb begin
        w_div_start = 1'b0;
        w_div_num   = '0;
        w_div_den   = '0;
        if (r_state == S_MUL && r_root != '0) begin
            w_div_start = 1'b1;
            w_div_num   = 64'(w_dmag) * 64'(w_head.mass);
            w_div_den   = 64'(r_root);
        end else if (r_state == S_DV1 && w_div_done) begin
            w_div_start = 1'b1;
            w_div_num   = {w_q[47:0], 16'd0};
            w_div_den   = 64'(r_d2);
        end
    end

    agc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    // gain scaling of one axis
    logic signed [SW-1:0] w_ssel;
    logic [SW-1:0]        w_smag;
    logic [SW+31:0]       w_scaled;
    logic [31:0]          w_fout;

    assign w_ssel   = r_sum[r_ax];
    assign w_smag   = w_ssel[SW-1] ? SW'(-w_ssel) : SW'(w_ssel);
    assign w_scaled = (SW+32)'(w_smag[SW-1:32] * r_gain) + (SW+32)'(r_p);

    always_comb begin
        if (w_ssel[SW-1]) begin
            w_fout = (w_scaled > (SW+32)'(32'h8000_0000)) ? 32'h8000_0000
                                                          : 32'(-w_scaled[31:0]);
        end else begin
            w_fout = (w_scaled > (SW+32)'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF
                                                          : w_scaled[31:0];
        end
    end

    // configuration port
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= COUNT_RST;
            r_sun    <= SUN_RST;
            r_gain   <= GAIN_RST;
            r_margin <= MARGIN_RST;
        end else if (w_cfg_wr) begin
            case (paddr[3:2])
                REG_COUNT:  r_count  <= pwdata[4:0];
                REG_SUN:    r_sun    <= pwdata;
                REG_GAIN:   r_gain   <= pwdata;
                REG_MARGIN: r_margin <= pwdata;
                default:    r_count  <= r_count;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_COUNT:  prdata = {27'd0, r_count};
            REG_SUN:    prdata = r_sun;
            REG_GAIN:   prdata = r_gain;
            REG_MARGIN: prdata = r_margin;
            default:    prdata = '0;
        endcase
    end

    // sequencer
    logic w_k_last;
    assign w_k_last = (r_k == KW'(MAX_PLANETS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ax     <= '0;
            r_k      <= '0;
            r_n      <= '0;
            r_at_sun <= 1'b0;
            r_hit    <= 1'b0;
            r_it     <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_acc && i_req.data.kind == KIND_QUERY) begin
                        r_n      <= (32'(r_count) > MAX_PLANETS) ? KW'(MAX_PLANETS)
                                                                 : KW'(r_count);
                        r_at_sun <= 1'b1;
                        r_hit    <= 1'b0;
                        r_ax     <= '0;
                        r_k      <= '0;
                        r_state  <= S_CSQ;
                    end
                end
                S_CSQ: begin
                    if (r_ax == 2'd3) begin
                        r_ax    <= '0;
                        r_state <= S_CCMP;
                    end else begin
                        r_ax <= r_ax + 2'd1;
                    end
                end
                S_CCMP: begin
                    if (r_d2 < r_lim) begin
                        r_hit <= 1'b1;
                    end
                    if (r_at_sun) begin
                        r_at_sun <= 1'b0;
                        r_state  <= S_CPL;
                    end else begin
                        r_state <= S_CSH;
                    end
                end
                S_CPL: begin
                    r_state <= (r_k < r_n && !r_hit) ? S_CSQ : S_CSH;
                end
                S_CSH: begin
                    if (w_k_last) begin
                        r_k     <= '0;
                        r_state <= r_hit ? S_OUT : S_FPL;
                    end else begin
                        r_k     <= r_k + KW'(1);
                        r_state <= S_CPL;
                    end
                end
                S_FPL: begin
                    r_ax    <= '0;
                    r_state <= (r_k < r_n) ? S_FSQ : S_FSH;
                end
                S_FSQ: begin
                    if (r_ax == 2'd2) begin
                        r_ax    <= '0;
                        r_state <= S_FCHK;
                    end else begin
                        r_ax <= r_ax + 2'd1;
                    end
                end
                S_FCHK: begin
                    if (r_d2 == '0 || r_d2 < D2_W'(r_margin)) begin
                        r_state <= S_FSH;
                    end else begin
                        r_it    <= 6'd33;
                        r_state <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    if (r_it == '0) begin
                        r_state <= S_MUL;
                    end else begin
                        r_it <= r_it - 6'd1;
                    end
                end
                S_MUL: begin
                    r_state <= (r_root == '0) ? S_FSH : S_DV1;
                end
                S_DV1: begin
                    if (w_div_done) begin
                        r_state <= S_DV2;
                    end
                end
                S_DV2: begin
                    if (w_div_done) begin
                        if (r_ax == 2'd2) begin
                            r_ax    <= '0;
                            r_state <= S_FSH;
                        end else begin
                            r_ax    <= r_ax + 2'd1;
                            r_state <= S_MUL;
                        end
                    end
                end
                S_FSH: begin
                    if (w_k_last) begin
                        r_k     <= '0;
                        r_ax    <= '0;
                        r_state <= S_SC1;
                    end else begin
                        r_k     <= r_k + KW'(1);
                        r_state <= S_FPL;
                    end
                end
                S_SC1: begin
                    r_state <= S_SC2;
                end
                S_SC2: begin
                    if (r_ax == 2'd2) begin
                        r_ax    <= '0;
                        r_state <= S_OUT;
                    end else begin
                        r_ax    <= r_ax + 2'd1;
                        r_state <= S_SC1;
                    end
                end
                S_OUT: begin
                    if (o_rsp.ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_px   <= i_req.data.pos_x;
                r_py   <= i_req.data.pos_y;
                r_pz   <= i_req.data.pos_z;
                r_arad <= i_req.data.body_radius;
                r_d2   <= '0;
                for (int a = 0; a < 3; a++) begin
                    r_sum[a]   <= '0;
                    r_force[a] <= '0;
                end
            end
            S_CSQ: begin
                if (r_ax == 2'd3) begin
                    r_lim <= w_sq + D2_W'(r_margin);
                end else begin
                    r_d2 <= r_d2 + w_sq;
                end
            end
            S_CPL, S_FPL: begin
                r_d2 <= '0;
            end
            S_FSQ: begin
                r_d2 <= r_d2 + w_sq;
            end
            S_FCHK: begin
                r_rem  <= '0;
                r_root <= '0;
                r_sx   <= {r_d2[51:0], 16'd0};
            end
            S_SQRT: begin
                // one result bit per step, two radicand bits in
                if (w_rem_s >= w_trial) begin
                    r_rem  <= w_rem_s - w_trial;
                    r_root <= {r_root[32:0], 1'b1};
                end else begin
                    r_rem  <= w_rem_s;
                    r_root <= {r_root[32:0], 1'b0};
                end
                r_sx <= {r_sx[65:0], 2'b00};
            end
            S_DV2: begin
                if (w_div_done) begin
                    r_sum[r_ax] <= w_dsel[32] ? r_sum[r_ax] - $signed(SW'(w_t))
                                              : r_sum[r_ax] + $signed(SW'(w_t));
                end
            end
            S_SC1: begin
                r_p <= 32'((64'(w_smag[31:0]) * 64'(r_gain)) >> 32);
            end
            S_SC2: begin
                r_force[r_ax] <= w_fout;
            end
            default: begin
                r_p <= r_p;
            end
        endcase
    end

    // request and response ports
    assign i_req.ready            = (r_state == S_IDLE);
    assign o_rsp.valid            = (r_state == S_OUT);
    assign o_rsp.data.collided    = r_hit;
    assign o_rsp.data.force_x     = r_force[0];
    assign o_rsp.data.force_y     = r_force[1];
    assign o_rsp.data.force_z     = r_force[2];

endmodule
